/* hdl/mfb_pkg.sv */
// ----------------------------------------------------------------------------
// mfb_pkg
// Shared types, codes and helpers of the monochrome framebuffer refresh unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfb_pkg;

  // default geometry
  localparam int unsigned DefColumns = 128;
  localparam int unsigned DefPages   = 8;

  // row and page-group widths fixed by the largest screen (8 pages, 64 rows)
  localparam int unsigned RowW = 6;
  localparam int unsigned GrpW = 3;

  // controller command bytes
  localparam logic [7:0] CmdPageBase = 8'hB0;
  localparam logic [7:0] CmdColLow   = 8'h00;
  localparam logic [7:0] CmdColHigh  = 8'h10;

  // header length of each page in the refresh stream
  localparam int unsigned HeaderLen = 3;

  // request action codes
  typedef enum logic [1:0] {
    ACT_POINT   = 2'd0,
    ACT_FILL    = 2'd1,
    ACT_CLEAR   = 2'd2,
    ACT_REFRESH = 2'd3
  } action_e;

  // control of the pixel store port
  typedef struct packed {
    logic rd;
    logic wr;
  } mem_cmd_t;

  // bits of one page byte covered by rows lo..hi of the group, row 0 at bit 7
  function automatic logic [7:0] row_mask(logic [2:0] lo, logic [2:0] hi);
    logic [7:0] m;
    m = '0;
    for (int k = 0; k < 8; k++) begin
      m[7-k] = (3'(k) >= lo) && (3'(k) <= hi);
    end
    return m;
  endfunction

endpackage

/* hdl/mfb_store.sv */
// ----------------------------------------------------------------------------
// mfb_store
// Single-port pixel store, one page byte per entry, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfb_store #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic              clk_i,
  input  mfb_pkg::mem_cmd_t cmd_i,
  input  logic [AddrW-1:0]  addr_i,
  input  logic [7:0]        wr_data_i,
  output logic [7:0]        rd_data_o
);
  import mfb_pkg::*;

  logic [7:0] mem_q [Depth];
  logic [7:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_data_q <= mem_q[addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hdl/mono_framebuffer_page_refresh_unit.sv */
// ----------------------------------------------------------------------------
// mono_framebuffer_page_refresh_unit
// Page-mode framebuffer with point, rectangle fill, clear and refresh stream.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low; busy_o stays high
// until the request is finished. Refresh requests (action 3) pass through
// S_REF_RD, which reads the store for data bytes, and then S_REF_OUT, which
// shows their byte on valid_o for one cycle; the receiver cannot stall it.
// The single-port pixel store is reached by one read-modify-write sequencer:
// a fill or a point reads and then writes each page byte touched
// (columns times page groups covered), an empty or off-screen draw touches
// no byte, and a clear writes every byte. After reset the store is swept to
// zero, which holds busy_o high until the sweep is done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mono_framebuffer_page_refresh_unit #(
  parameter int unsigned COLUMNS = mfb_pkg::DefColumns,
  parameter int unsigned PAGES   = mfb_pkg::DefPages
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] action_i,
  input  logic [7:0] x_start_i,
  input  logic [7:0] y_start_i,
  input  logic [7:0] x_end_i,
  input  logic [7:0] y_end_i,
  input  logic       pixel_on_i,
  output logic       valid_o,
  output logic [7:0] out_byte_o,
  output logic       is_data_o,
  output logic       frame_last_o
);
  import mfb_pkg::*;

  localparam int unsigned Rows  = PAGES * 8;
  localparam int unsigned Depth = COLUMNS * PAGES;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned ColW  = $clog2(COLUMNS);
  localparam int unsigned PosW  = $clog2(COLUMNS + HeaderLen);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_CLEAR   = 6'b000010,
    S_FILL_RD = 6'b000100,
    S_FILL_WR = 6'b001000,
    S_REF_RD  = 6'b010000,
    S_REF_OUT = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [AddrW-1:0]  clr_q, clr_d;
  logic [ColW-1:0]   x_q, x_d;
  logic [ColW-1:0]   x_last_q, x_last_d;
  logic [GrpW-1:0]   g_q, g_d;
  logic [RowW-1:0]   y_lo_q, y_lo_d;
  logic [RowW-1:0]   y_hi_q, y_hi_d;
  logic              on_q, on_d;
  logic [GrpW-1:0]   page_q, page_d;
  logic [PosW-1:0]   pos_q, pos_d;

  logic              accept;
  action_e           action;
  logic [8:0]        xs_ext, ys_ext, xe_eff, ye_eff, xe_clip, ye_clip;
  logic              draw_empty;
  logic [2:0]        mask_lo, mask_hi;
  logic [7:0]        mask;
  logic              pos_is_data;
  logic [ColW-1:0]   ref_col;
  logic [GrpW-1:0]   fill_page;
  mem_cmd_t          mem_cmd;
  logic [AddrW-1:0]  mem_addr;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_rdata;

  // store address of a column and page
  function automatic logic [AddrW-1:0] byte_addr(logic [ColW-1:0] col, logic [GrpW-1:0] pg);
    return AddrW'(AddrW'(col) * AddrW'(PAGES)) + AddrW'(pg);
  endfunction

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;
  assign action = action_e'(action_i);

  // clip the drawing window; a point is a one-pixel rectangle
  always_comb begin
    xs_ext     = {1'b0, x_start_i};
    ys_ext     = {1'b0, y_start_i};
    xe_eff     = (action == ACT_POINT) ? xs_ext : {1'b0, x_end_i};
    ye_eff     = (action == ACT_POINT) ? ys_ext : {1'b0, y_end_i};
    xe_clip    = (xe_eff > 9'(COLUMNS - 1)) ? 9'(COLUMNS - 1) : xe_eff;
    ye_clip    = (ye_eff > 9'(Rows - 1)) ? 9'(Rows - 1) : ye_eff;
    draw_empty = (xs_ext > xe_clip) || (ys_ext > ye_clip);
  end

  // bits of the current page byte inside the row window
  always_comb begin
    mask_lo   = (g_q == y_lo_q[RowW-1:3]) ? y_lo_q[2:0] : 3'd0;
    mask_hi   = (g_q == y_hi_q[RowW-1:3]) ? y_hi_q[2:0] : 3'd7;
    mask      = row_mask(mask_lo, mask_hi);
    fill_page = GrpW'(PAGES - 1) - g_q;
  end

  // refresh cursor decode
  assign pos_is_data = (pos_q >= PosW'(HeaderLen));
  assign ref_col     = ColW'(pos_q - PosW'(HeaderLen));

  // sequencer
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    x_d       = x_q;
    x_last_d  = x_last_q;
    g_d       = g_q;
    y_lo_d    = y_lo_q;
    y_hi_d    = y_hi_q;
    on_d      = on_q;
    page_d    = page_q;
    pos_d     = pos_q;
    mem_cmd   = '0;
    mem_addr  = byte_addr(x_q, fill_page);
    mem_wdata = on_q ? (mem_rdata | mask) : (mem_rdata & ~mask);

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (action) inside
            ACT_POINT, ACT_FILL: begin
              x_d      = ColW'(xs_ext);
              x_last_d = ColW'(xe_clip);
              y_lo_d   = RowW'(ys_ext);
              y_hi_d   = RowW'(ye_clip);
              g_d      = ys_ext[RowW-1:3];
              on_d     = pixel_on_i;
              state_d  = draw_empty ? S_IDLE : S_FILL_RD;
            end
            ACT_CLEAR: begin
              clr_d   = '0;
              state_d = S_CLEAR;
            end
            default: begin
              state_d = S_REF_RD;
            end
          endcase
        end
      end
      S_CLEAR: begin
        mem_cmd.wr = 1'b1;
        mem_addr   = clr_q;
        mem_wdata  = '0;
        if (clr_q == AddrW'(Depth - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      S_FILL_RD: begin
        mem_cmd.rd = 1'b1;
        state_d    = S_FILL_WR;
      end
      S_FILL_WR: begin
        mem_cmd.wr = 1'b1;
        state_d    = S_FILL_RD;
        // walk page groups, then columns
        if (g_q == y_hi_q[RowW-1:3]) begin
          g_d = y_lo_q[RowW-1:3];
          if (x_q == x_last_q) begin
            state_d = S_IDLE;
          end else begin
            x_d = x_q + 1'b1;
          end
        end else begin
          g_d = g_q + 1'b1;
        end
      end
      S_REF_RD: begin
        mem_cmd.rd = pos_is_data;
        mem_addr   = byte_addr(ref_col, page_q);
        state_d    = S_REF_OUT;
      end
      S_REF_OUT: begin
        state_d = S_IDLE;
        // advance the refresh cursor, wrapping at page and frame end
        if (pos_q == PosW'(COLUMNS + HeaderLen - 1)) begin
          pos_d  = '0;
          page_d = (page_q == GrpW'(PAGES - 1)) ? '0 : page_q + 1'b1;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      page_q  <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      page_q  <= page_d;
      pos_q   <= pos_d;
    end
  end

  // drawing window registers
  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    x_last_q <= x_last_d;
    g_q      <= g_d;
    y_lo_q   <= y_lo_d;
    y_hi_q   <= y_hi_d;
    on_q     <= on_d;
  end

  mfb_store #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .cmd_i     (mem_cmd),
    .addr_i    (mem_addr),
    .wr_data_i (mem_wdata),
    .rd_data_o (mem_rdata)
  );

  // result byte
  always_comb begin
    valid_o      = (state_q == S_REF_OUT);
    is_data_o    = pos_is_data;
    frame_last_o = valid_o && (pos_q == PosW'(COLUMNS + HeaderLen - 1))
                   && (page_q == GrpW'(PAGES - 1));
    case (pos_q)
      PosW'(0): out_byte_o = CmdPageBase + {{(8 - GrpW){1'b0}}, page_q};
      PosW'(1): out_byte_o = CmdColLow;
      PosW'(2): out_byte_o = CmdColHigh;
      default:  out_byte_o = mem_rdata;
    endcase
  end

  // checks
  a_valid_after_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q == S_REF_RD))
    else $error("result strobe without a refresh read");

  a_last_is_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_last_o |-> (valid_o && is_data_o))
    else $error("frame end flagged on a command byte");

  a_wrap_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_last_o |=> (page_q == '0 && pos_q == '0))
    else $error("refresh cursor did not wrap after frame end");

  a_no_write_refresh : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REF_RD || state_q == S_REF_OUT) |-> !mem_cmd.wr)
    else $error("store written during refresh");

endmodule
